### hw/rtl/i2ctf_pkg.sv
// Shared types, constants and codes of the I2C transaction filter.
`timescale 1ns / 1ps
`default_nettype none

package i2ctf_pkg;

    // Buffer geometry.
    localparam int BUFFER_DEPTH = 64;
    localparam int MAX_BYTES    = 8;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);

    // Field widths.
    localparam int KIND_W    = 4;
    localparam int SAMPLE_W  = 48;
    localparam int PAYLOAD_W = 64;
    localparam int COUNT_W   = 4;
    localparam int SLAVE_W   = 8;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;
    localparam int MATCH_W     = 7;
    localparam int DIR_W       = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS_MATCH   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION_MATCH = 1'd1;

    // Event kind codes.
    localparam logic [KIND_W-1:0] KIND_START_REPEAT = 4'd1;
    localparam logic [KIND_W-1:0] KIND_STOP         = 4'd2;
    localparam logic [KIND_W-1:0] KIND_ADDR_READ    = 4'd6;
    localparam logic [KIND_W-1:0] KIND_ADDR_WRITE   = 4'd7;

    // Direction codes.
    localparam logic [DIR_W-1:0] DIR_ANY = 2'd0;
    localparam logic [DIR_W-1:0] DIR_RD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_WR  = 2'd2;

    // One buffered event.
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [SAMPLE_W-1:0]  first_sample;
        logic [SAMPLE_W-1:0]  final_sample;
        logic [PAYLOAD_W-1:0] payload;
        logic [COUNT_W-1:0]   payload_count;
    } i2ctf_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;       // input item accepted this cycle
        logic first_read;  // start a drain at buffer entry zero
        logic next_read;   // step to the next buffer entry
        logic clear;       // empty the buffer
    } i2ctf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_close;    // incoming item is STOP or START REPEAT
        logic passes;      // current transaction passes both filters
        logic at_last;     // the entry on the output is the last one
    } i2ctf_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SHOW
    } i2ctf_state_t;

endpackage

`default_nettype wire

### hw/rtl/i2ctf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module i2ctf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/i2ctf_datapath.sv
// Datapath: event buffer, fill level, address state, filters and read pointer.
`timescale 1ns / 1ps
`default_nettype none

module i2ctf_datapath (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [i2ctf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [i2ctf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic [i2ctf_pkg::KIND_W-1:0]          s_event_kind,
    input  wire logic [i2ctf_pkg::SAMPLE_W-1:0]        s_first_sample,
    input  wire logic [i2ctf_pkg::SAMPLE_W-1:0]        s_final_sample,
    input  wire logic [i2ctf_pkg::PAYLOAD_W-1:0]       s_payload,
    input  wire logic [i2ctf_pkg::COUNT_W-1:0]         s_payload_count,
    input  wire i2ctf_pkg::i2ctf_cmd_t                 cmd,
    output i2ctf_pkg::i2ctf_status_t                   status,
    output i2ctf_pkg::i2ctf_entry_t                    out_entry
);

    logic [i2ctf_pkg::MATCH_W-1:0] address_match_reg;
    logic [i2ctf_pkg::DIR_W-1:0]   direction_match_reg;
    logic [i2ctf_pkg::FILL_W-1:0]  fill_level_reg, fill_level_next;
    logic [i2ctf_pkg::SLAVE_W-1:0] current_address_reg, current_address_next;
    logic                          address_known_reg, address_known_next;
    logic [i2ctf_pkg::DIR_W-1:0]   current_direction_reg, current_direction_next;
    logic [i2ctf_pkg::ADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;

    logic                          buffer_full;
    logic                          is_addr_event;
    logic [i2ctf_pkg::COUNT_W-1:0] kept_count;
    logic [i2ctf_pkg::PAYLOAD_W-1:0] kept_payload;
    i2ctf_pkg::i2ctf_entry_t       wr_entry;
    logic                          addr_ok;
    logic                          dir_ok;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            address_match_reg   <= '0;
            direction_match_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                i2ctf_pkg::REG_ADDRESS_MATCH: begin
                    address_match_reg <= cfg_data[i2ctf_pkg::MATCH_W-1:0];
                end
                i2ctf_pkg::REG_DIRECTION_MATCH: begin
                    direction_match_reg <= cfg_data[i2ctf_pkg::DIR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Byte count is clipped and bytes beyond it are forced to zero.
    always_comb begin
        kept_count = (s_payload_count > i2ctf_pkg::COUNT_W'(i2ctf_pkg::MAX_BYTES))
                   ? i2ctf_pkg::COUNT_W'(i2ctf_pkg::MAX_BYTES) : s_payload_count;
        for (int i = 0; i < i2ctf_pkg::PAYLOAD_W / 8; i++) begin
            kept_payload[i*8 +: 8] = (i2ctf_pkg::COUNT_W'(i) < kept_count)
                                   ? s_payload[i*8 +: 8] : 8'h00;
        end
    end

    assign wr_entry.kind          = s_event_kind;
    assign wr_entry.first_sample  = s_first_sample;
    assign wr_entry.final_sample  = s_final_sample;
    assign wr_entry.payload       = kept_payload;
    assign wr_entry.payload_count = kept_count;

    assign buffer_full   = (fill_level_reg == i2ctf_pkg::FILL_W'(i2ctf_pkg::BUFFER_DEPTH));
    assign is_addr_event = (s_event_kind == i2ctf_pkg::KIND_ADDR_READ) ||
                           (s_event_kind == i2ctf_pkg::KIND_ADDR_WRITE);

    // A closing event never changes the address state, so the registered
    // state is the one the filters see.
    assign addr_ok = (address_match_reg == '0) ||
                     (address_known_reg &&
                      (current_address_reg == {1'b0, address_match_reg}));
    assign dir_ok  = (direction_match_reg == i2ctf_pkg::DIR_ANY) ||
                     (current_direction_reg == direction_match_reg);

    assign status.is_close = (s_event_kind == i2ctf_pkg::KIND_STOP) ||
                             (s_event_kind == i2ctf_pkg::KIND_START_REPEAT);
    assign status.passes   = addr_ok && dir_ok;
    assign status.at_last  = ((i2ctf_pkg::FILL_W'(rd_ptr_reg) + i2ctf_pkg::FILL_W'(1))
                              == fill_level_reg);

    always_comb begin
        fill_level_next        = fill_level_reg;
        current_address_next   = current_address_reg;
        address_known_next     = address_known_reg;
        current_direction_next = current_direction_reg;
        rd_ptr_next            = rd_ptr_reg;

        if (cmd.store && !buffer_full) begin
            fill_level_next = fill_level_reg + i2ctf_pkg::FILL_W'(1);
        end
        if (cmd.clear) begin
            fill_level_next = '0;
        end
        if (cmd.store && is_addr_event) begin
            current_address_next   = (s_payload_count != '0) ? s_payload[7:0] : '0;
            address_known_next     = 1'b1;
            current_direction_next = (s_event_kind == i2ctf_pkg::KIND_ADDR_READ)
                                   ? i2ctf_pkg::DIR_RD : i2ctf_pkg::DIR_WR;
        end
        if (cmd.first_read) begin
            rd_ptr_next = '0;
        end else if (cmd.next_read) begin
            rd_ptr_next = rd_ptr_reg + i2ctf_pkg::ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_level_reg        <= '0;
            current_address_reg   <= '0;
            address_known_reg     <= 1'b0;
            current_direction_reg <= i2ctf_pkg::DIR_ANY;
            rd_ptr_reg            <= '0;
        end else begin
            fill_level_reg        <= fill_level_next;
            current_address_reg   <= current_address_next;
            address_known_reg     <= address_known_next;
            current_direction_reg <= current_direction_next;
            rd_ptr_reg            <= rd_ptr_next;
        end
    end

    i2ctf_ram #(
        .WIDTH ($bits(i2ctf_pkg::i2ctf_entry_t)),
        .DEPTH (i2ctf_pkg::BUFFER_DEPTH)
    ) u_buffer (
        .aclk    (aclk),
        .wr_en   (cmd.store && !buffer_full),
        .wr_addr (fill_level_reg[i2ctf_pkg::ADDR_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (cmd.first_read || cmd.next_read),
        .rd_addr (rd_ptr_next),
        .rd_data (out_entry)
    );

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_level_reg <= i2ctf_pkg::FILL_W'(i2ctf_pkg::BUFFER_DEPTH))
        else $error("fill level beyond buffer depth");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.next_read |-> !status.at_last)
        else $error("read pointer stepped past the last buffered item");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> (fill_level_reg == '0))
        else $error("buffer not emptied after clear");

endmodule

`default_nettype wire

### hw/rtl/i2ctf_ctrl.sv
// Controller state machine: accepts items and sequences the buffer drain.
`timescale 1ns / 1ps
`default_nettype none

module i2ctf_ctrl (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    input  wire i2ctf_pkg::i2ctf_status_t status,
    output i2ctf_pkg::i2ctf_cmd_t         cmd
);

    i2ctf_pkg::i2ctf_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= i2ctf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd        = '0;
        case (state_reg)
            i2ctf_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.store = 1'b1;
                    if (status.is_close) begin
                        if (status.passes) begin
                            state_next = i2ctf_pkg::ST_FETCH;
                        end else begin
                            cmd.clear = 1'b1;
                        end
                    end
                end
            end
            i2ctf_pkg::ST_FETCH: begin
                cmd.first_read = 1'b1;
                state_next     = i2ctf_pkg::ST_SHOW;
            end
            i2ctf_pkg::ST_SHOW: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (status.at_last) begin
                        cmd.clear  = 1'b1;
                        state_next = i2ctf_pkg::ST_IDLE;
                    end else begin
                        cmd.next_read = 1'b1;
                    end
                end
            end
            default: begin
                state_next = i2ctf_pkg::ST_IDLE;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a burst is being delivered");

    a_burst_follows_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && status.is_close && status.passes) |=> ##1 m_valid)
        else $error("passing transaction did not start a burst");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && status.at_last) |=> (s_ready && !m_valid))
        else $error("block did not return to idle after the last item");

endmodule

`default_nettype wire

### hw/rtl/i2c_transaction_filter_top.sv
// Top level of the I2C transaction filter: controller, datapath and ports.
//
//  Channel  | Ports                                   | Direction | Handshake
//  ---------+-----------------------------------------+-----------+----------------
//  config   | cfg_wr_en, cfg_index, cfg_data          | in        | write on enable
//  events   | s_valid/s_ready, s_event_kind ...       | in        | valid/ready
//  results  | m_valid/m_ready, m_out_kind ...         | out       | valid/ready
//
// An event that does not close a transaction, or closes one that fails the
// filters, is accepted and the block is ready again the next cycle.
// A closing event that passes is accepted, then the block fetches buffer
// entry zero and forwards one item per cycle while m_ready is high; the
// single read port of the buffer RAM sets the one-item-per-cycle drain.
// Input is held off during the drain.
// Reset is synchronous and active low; the buffer needs no clearing pass, so
// the block accepts items as soon as reset is released.
// A stall on m_ready holds the current item and its fields unchanged.
`timescale 1ns / 1ps
`default_nettype none

module i2c_transaction_filter_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    // Configuration writes: index 0 address_match, index 1 direction_match.
    input  wire logic                              cfg_wr_en,
    input  wire logic [i2ctf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [i2ctf_pkg::CFG_DATA_W-1:0]  cfg_data,

    // Decoded protocol events.
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [i2ctf_pkg::KIND_W-1:0]      s_event_kind,
    input  wire logic [i2ctf_pkg::SAMPLE_W-1:0]    s_first_sample,
    input  wire logic [i2ctf_pkg::SAMPLE_W-1:0]    s_final_sample,
    input  wire logic [i2ctf_pkg::PAYLOAD_W-1:0]   s_payload,
    input  wire logic [i2ctf_pkg::COUNT_W-1:0]     s_payload_count,

    // Forwarded events of passing transactions.
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [i2ctf_pkg::KIND_W-1:0]           m_out_kind,
    output logic [i2ctf_pkg::SAMPLE_W-1:0]         m_out_first_sample,
    output logic [i2ctf_pkg::SAMPLE_W-1:0]         m_out_final_sample,
    output logic [i2ctf_pkg::PAYLOAD_W-1:0]        m_out_payload,
    output logic [i2ctf_pkg::COUNT_W-1:0]          m_out_payload_count,
    output logic                                   m_last_of_burst
);

    i2ctf_pkg::i2ctf_cmd_t    cmd;
    i2ctf_pkg::i2ctf_status_t status;
    i2ctf_pkg::i2ctf_entry_t  out_entry;

    // The controller owns both handshakes; the datapath never sees valid or
    // ready directly, only the commands derived from them.
    i2ctf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath buffers every event (until the buffer is full), tracks the
    // slave address and direction, and evaluates both filters.
    i2ctf_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_event_kind    (s_event_kind),
        .s_first_sample  (s_first_sample),
        .s_final_sample  (s_final_sample),
        .s_payload       (s_payload),
        .s_payload_count (s_payload_count),
        .cmd             (cmd),
        .status          (status),
        .out_entry       (out_entry)
    );

    // The result fields come straight from the registered RAM read data,
    // which only changes when the controller fetches entry zero or steps to the next entry.
    assign m_out_kind          = out_entry.kind;
    assign m_out_first_sample  = out_entry.first_sample;
    assign m_out_final_sample  = out_entry.final_sample;
    assign m_out_payload       = out_entry.payload;
    assign m_out_payload_count = out_entry.payload_count;
    assign m_last_of_burst     = status.at_last;

endmodule

`default_nettype wire

### test/i2ctf_burst_checker.sv
// Checker for the I2C transaction filter: predicts forwarded items and compares them.
`timescale 1ns / 1ps

module i2ctf_burst_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_wr_en,
    input  wire logic [i2ctf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [i2ctf_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                              s_valid,
    input  wire logic                              s_ready,
    input  wire logic [i2ctf_pkg::KIND_W-1:0]      s_event_kind,
    input  wire logic [i2ctf_pkg::SAMPLE_W-1:0]    s_first_sample,
    input  wire logic [i2ctf_pkg::SAMPLE_W-1:0]    s_final_sample,
    input  wire logic [i2ctf_pkg::PAYLOAD_W-1:0]   s_payload,
    input  wire logic [i2ctf_pkg::COUNT_W-1:0]     s_payload_count,

    input  wire logic                              m_valid,
    input  wire logic                              m_ready,
    input  wire logic [i2ctf_pkg::KIND_W-1:0]      m_out_kind,
    input  wire logic [i2ctf_pkg::SAMPLE_W-1:0]    m_out_first_sample,
    input  wire logic [i2ctf_pkg::SAMPLE_W-1:0]    m_out_final_sample,
    input  wire logic [i2ctf_pkg::PAYLOAD_W-1:0]   m_out_payload,
    input  wire logic [i2ctf_pkg::COUNT_W-1:0]     m_out_payload_count,
    input  wire logic                              m_last_of_burst,

    output int                                     fail_count,
    output int                                     pending_count
);

    import i2ctf_pkg::*;

    typedef struct packed {
        i2ctf_entry_t entry;
        logic         last;
    } forwarded_t;

    forwarded_t         awaited_items[$];
    i2ctf_entry_t       held_events[BUFFER_DEPTH];
    int                 held_count;
    logic [SLAVE_W-1:0] bus_address;
    logic               address_seen;
    logic [DIR_W-1:0]   bus_direction;
    logic [MATCH_W-1:0] want_address;
    logic [DIR_W-1:0]   want_direction;
    int                 mismatches;
    int                 results_seen;
    i2ctf_entry_t       incoming;
    forwarded_t         observed;

    // Bytes at or above the kept count read as zero.
    function automatic logic [PAYLOAD_W-1:0] trim_payload(input logic [PAYLOAD_W-1:0] data,
                                                          input logic [COUNT_W-1:0] kept);
        logic [PAYLOAD_W-1:0] result;
        result = '0;
        for (int b = 0; b < MAX_BYTES; b++) begin
            if (b < kept) result[8*b +: 8] = data[8*b +: 8];
        end
        return result;
    endfunction

    function automatic bit filters_pass();
        if (want_address != '0 &&
            (!address_seen || bus_address != {1'b0, want_address})) return 1'b0;
        if (want_direction != DIR_ANY && bus_direction != want_direction) return 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Buffers one accepted event and, when it closes a passing transaction,
    // queues the whole buffer as the burst the block has to forward.
    task automatic absorb_event(input i2ctf_entry_t ev);
        i2ctf_entry_t     stored;
        logic [COUNT_W-1:0] kept;
        forwarded_t       item;
        kept = (ev.payload_count > MAX_BYTES) ? COUNT_W'(MAX_BYTES) : ev.payload_count;
        stored = ev;
        stored.payload_count = kept;
        stored.payload = trim_payload(ev.payload, kept);
        if (held_count < BUFFER_DEPTH) begin
            held_events[held_count] = stored;
            held_count++;
        end
        if (ev.kind == KIND_ADDR_READ || ev.kind == KIND_ADDR_WRITE) begin
            bus_address = (ev.payload_count != '0) ? ev.payload[7:0] : '0;
            address_seen = 1'b1;
            bus_direction = (ev.kind == KIND_ADDR_READ) ? DIR_RD : DIR_WR;
        end else if (ev.kind == KIND_STOP || ev.kind == KIND_START_REPEAT) begin
            if (filters_pass()) begin
                for (int i = 0; i < held_count; i++) begin
                    item.entry = held_events[i];
                    item.last = (i + 1 == held_count);
                    awaited_items.push_back(item);
                end
            end
            held_count = 0;
        end
    endtask

    task automatic check_result(input forwarded_t got);
        forwarded_t want;
        results_seen++;
        if (awaited_items.size() == 0) begin
            report_mismatch($sformatf("item %0d of kind %0d was not expected",
                                      results_seen, got.entry.kind));
        end else begin
            want = awaited_items.pop_front();
            if (got.entry.kind != want.entry.kind)
                report_mismatch($sformatf("item %0d out_kind %0d, expected %0d", results_seen,
                                          got.entry.kind, want.entry.kind));
            if (got.entry.first_sample != want.entry.first_sample)
                report_mismatch($sformatf("item %0d out_first_sample %h, expected %h",
                                          results_seen, got.entry.first_sample,
                                          want.entry.first_sample));
            if (got.entry.final_sample != want.entry.final_sample)
                report_mismatch($sformatf("item %0d out_final_sample %h, expected %h",
                                          results_seen, got.entry.final_sample,
                                          want.entry.final_sample));
            if (got.entry.payload != want.entry.payload)
                report_mismatch($sformatf("item %0d out_payload %h, expected %h", results_seen,
                                          got.entry.payload, want.entry.payload));
            if (got.entry.payload_count != want.entry.payload_count)
                report_mismatch($sformatf("item %0d out_payload_count %0d, expected %0d",
                                          results_seen, got.entry.payload_count,
                                          want.entry.payload_count));
            if (got.last !== want.last)
                report_mismatch($sformatf("item %0d last_of_burst %b, expected %b",
                                          results_seen, got.last, want.last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            awaited_items.delete();
            held_count = 0;
            bus_address = '0;
            address_seen = 1'b0;
            bus_direction = DIR_ANY;
            want_address = '0;
            want_direction = DIR_ANY;
            mismatches = 0;
            results_seen = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ADDRESS_MATCH:   want_address = cfg_data[MATCH_W-1:0];
                    REG_DIRECTION_MATCH: want_direction = cfg_data[DIR_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                incoming.kind = s_event_kind;
                incoming.first_sample = s_first_sample;
                incoming.final_sample = s_final_sample;
                incoming.payload = s_payload;
                incoming.payload_count = s_payload_count;
                absorb_event(incoming);
            end
            if (m_valid && m_ready) begin
                observed.entry.kind = m_out_kind;
                observed.entry.first_sample = m_out_first_sample;
                observed.entry.final_sample = m_out_final_sample;
                observed.entry.payload = m_out_payload;
                observed.entry.payload_count = m_out_payload_count;
                observed.last = m_last_of_burst;
                check_result(observed);
            end
        end
        fail_count <= mismatches;
        pending_count <= awaited_items.size();
    end

endmodule

### test/tb_i2c_transaction_filter_top.sv
// Testbench top for the I2C transaction filter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_i2c_transaction_filter_top;

    import i2ctf_pkg::*;

    // Event kinds that the package does not name.
    localparam logic [KIND_W-1:0] KIND_START      = 4'd0;
    localparam logic [KIND_W-1:0] KIND_ACK        = 4'd3;
    localparam logic [KIND_W-1:0] KIND_NACK       = 4'd4;
    localparam logic [KIND_W-1:0] KIND_BITS       = 4'd5;
    localparam logic [KIND_W-1:0] KIND_DATA_READ  = 4'd8;
    localparam logic [KIND_W-1:0] KIND_DATA_WRITE = 4'd9;
    localparam logic [KIND_W-1:0] KIND_OTHER      = 4'd10;
    localparam logic [KIND_W-1:0] KIND_TOP_CODE   = 4'd15;

    // The one direction code with no meaning; the filter then rejects everything.
    localparam logic [DIR_W-1:0] DIR_REJECT_ALL = 2'd3;

    localparam int RANDOM_ITEMS  = 230;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 50000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [KIND_W-1:0]      s_event_kind = '0;
    logic [SAMPLE_W-1:0]    s_first_sample = '0;
    logic [SAMPLE_W-1:0]    s_final_sample = '0;
    logic [PAYLOAD_W-1:0]   s_payload = '0;
    logic [COUNT_W-1:0]     s_payload_count = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [KIND_W-1:0]      m_out_kind;
    logic [SAMPLE_W-1:0]    m_out_first_sample;
    logic [SAMPLE_W-1:0]    m_out_final_sample;
    logic [PAYLOAD_W-1:0]   m_out_payload;
    logic [COUNT_W-1:0]     m_out_payload_count;
    logic                   m_last_of_burst;

    int fail_count;
    int pending_count;
    int items_sent = 0;

    // When set, the sender offers items back to back with no gaps.
    bit eager_sender = 1'b0;
    // Raised by the stimulus to ask the result side for one long hold-off.
    bit want_hold = 1'b0;

    always #6 aclk = ~aclk;

    i2c_transaction_filter_top dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_event_kind        (s_event_kind),
        .s_first_sample      (s_first_sample),
        .s_final_sample      (s_final_sample),
        .s_payload           (s_payload),
        .s_payload_count     (s_payload_count),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_out_kind          (m_out_kind),
        .m_out_first_sample  (m_out_first_sample),
        .m_out_final_sample  (m_out_final_sample),
        .m_out_payload       (m_out_payload),
        .m_out_payload_count (m_out_payload_count),
        .m_last_of_burst     (m_last_of_burst)
    );

    // The checker watches both channels and the register port on its own.
    i2ctf_burst_checker filter_check (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_event_kind        (s_event_kind),
        .s_first_sample      (s_first_sample),
        .s_final_sample      (s_final_sample),
        .s_payload           (s_payload),
        .s_payload_count     (s_payload_count),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_out_kind          (m_out_kind),
        .m_out_first_sample  (m_out_first_sample),
        .m_out_final_sample  (m_out_final_sample),
        .m_out_payload       (m_out_payload),
        .m_out_payload_count (m_out_payload_count),
        .m_last_of_burst     (m_last_of_burst),
        .fail_count          (fail_count),
        .pending_count       (pending_count)
    );

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        return SAMPLE_W'({$urandom, $urandom});
    endfunction

    function automatic logic [PAYLOAD_W-1:0] rand_payload();
        return {$urandom, $urandom};
    endfunction

    // Byte counts mostly stay within the legal range; now and then one is
    // too long so that the block has to cut it down to eight bytes.
    function automatic logic [COUNT_W-1:0] rand_count();
        if ($urandom_range(0, 7) == 0) return COUNT_W'($urandom_range(9, 15));
        return COUNT_W'($urandom_range(0, MAX_BYTES));
    endfunction

    // Gaps between items: mostly none or short, a few long ones.
    function automatic int pick_gap();
        if (eager_sender || $urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Kinds that sit between the address and the closing event.
    function automatic logic [KIND_W-1:0] pick_body_kind();
        case ($urandom_range(0, 11))
            0, 1:    return KIND_ACK;
            2:       return KIND_NACK;
            3, 4:    return KIND_BITS;
            5, 6, 7: return KIND_DATA_READ;
            8, 9:    return KIND_DATA_WRITE;
            default: return KIND_W'($urandom_range(KIND_OTHER, KIND_TOP_CODE));
        endcase
    endfunction

    // Offers one item and returns at the edge where it was accepted. Valid is
    // left high so that a following item can go out without a bubble; it is
    // only dropped when a gap is wanted or the sender goes idle.
    task automatic send_item(input logic [KIND_W-1:0] kind,
                             input logic [SAMPLE_W-1:0] first_at,
                             input logic [SAMPLE_W-1:0] final_at,
                             input logic [PAYLOAD_W-1:0] data,
                             input logic [COUNT_W-1:0] count);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_event_kind <= kind;
        s_first_sample <= first_at;
        s_final_sample <= final_at;
        s_payload <= data;
        s_payload_count <= count;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Lets every expected item drain, then a few more cycles so that a
    // closing event that failed the filters has surely finished as well.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_filters(input logic [MATCH_W-1:0] address, input logic [DIR_W-1:0] dir);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_ADDRESS_MATCH;
        cfg_data <= CFG_DATA_W'(address);
        @(posedge aclk);
        cfg_index <= REG_DIRECTION_MATCH;
        cfg_data <= CFG_DATA_W'(dir);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // One bus transaction: a start, usually an address, a body of protocol
    // events and a closing STOP or START REPEAT. The address mostly matches
    // the filter so that a good share of transactions gets forwarded.
    task automatic send_transaction(input logic [MATCH_W-1:0] target, input int body_len);
        logic [KIND_W-1:0]    addr_kind;
        logic [PAYLOAD_W-1:0] data;
        logic [COUNT_W-1:0]   count;
        send_item(($urandom_range(0, 7) == 0) ? KIND_START_REPEAT : KIND_START,
                  rand_sample(), rand_sample(), rand_payload(), rand_count());
        if ($urandom_range(0, 9) != 0) begin
            addr_kind = $urandom_range(0, 1) ? KIND_ADDR_READ : KIND_ADDR_WRITE;
            data = rand_payload();
            if ($urandom_range(0, 9) < 6) data[7:0] = {1'b0, target};
            if ($urandom_range(0, 9) == 0) count = '0;
            else if ($urandom_range(0, 9) == 0) count = COUNT_W'($urandom_range(9, 15));
            else count = COUNT_W'($urandom_range(1, MAX_BYTES));
            send_item(addr_kind, rand_sample(), rand_sample(), data, count);
        end
        repeat (body_len) begin
            send_item(pick_body_kind(), rand_sample(), rand_sample(), rand_payload(),
                      rand_count());
        end
        send_item(($urandom_range(0, 2) == 0) ? KIND_START_REPEAT : KIND_STOP,
                  rand_sample(), rand_sample(), rand_payload(), rand_count());
    endtask

    // Result side: ready toggles in runs of random length, mostly short with
    // a few long ones. On request it holds off for HOLD_CYCLES in a row so
    // that the buffer fills and the block has to stall its input.
    initial begin : result_sink
        int   run_left;
        logic level;
        run_left = 0;
        level = 1'b1;
        forever begin
            @(posedge aclk);
            if (want_hold) begin
                want_hold = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                run_left = 0;
            end else begin
                if (run_left == 0) begin
                    level = ($urandom_range(0, 3) != 0);
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                           : $urandom_range(1, 4);
                end
                m_ready <= level;
                run_left--;
            end
        end
    end

    initial begin : stimulus
        int                 base;
        int                 phase;
        int                 waited;
        logic [MATCH_W-1:0] target;
        logic [DIR_W-1:0]   dir;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // No address has been seen since reset, so a nonzero address filter
        // must reject this transaction.
        set_filters(7'd127, DIR_ANY);
        send_item(KIND_START, '0, '0, '0, '0);
        send_item(KIND_DATA_WRITE, rand_sample(), rand_sample(), rand_payload(), 4'd2);
        send_item(KIND_STOP, rand_sample(), rand_sample(), '0, '0);
        wait_idle();

        // Likewise a direction filter must fail while no direction is known;
        // the closing event is the only one in the buffer here.
        set_filters('0, DIR_RD);
        send_item(KIND_START_REPEAT, rand_sample(), rand_sample(), '0, '0);
        wait_idle();

        // Everything passes: field extremes, each kind but ADDR_READ and START_REPEAT,
        // an address event with no bytes (records address zero), long payloads that
        // get cut, and two of the unused kind codes that are simply carried along.
        set_filters('0, DIR_ANY);
        send_item(KIND_START, '0, '0, '0, '0);
        send_item(KIND_ADDR_WRITE, rand_sample(), rand_sample(), rand_payload(), '0);
        send_item(KIND_DATA_WRITE, '1, '1, '1, 4'd8);
        send_item(KIND_OTHER, rand_sample(), rand_sample(), '1, 4'd15);
        send_item(KIND_TOP_CODE, rand_sample(), rand_sample(), rand_payload(), 4'd9);
        send_item(KIND_ACK, rand_sample(), rand_sample(), rand_payload(), 4'd1);
        send_item(KIND_NACK, rand_sample(), rand_sample(), rand_payload(), '0);
        send_item(KIND_BITS, rand_sample(), rand_sample(), rand_payload(), 4'd7);
        send_item(KIND_DATA_READ, rand_sample(), rand_sample(), rand_payload(), 4'd3);
        send_item(KIND_STOP, rand_sample(), rand_sample(), rand_payload(), 4'd5);
        wait_idle();

        // Highest address with a write filter: the first transaction passes
        // and closes on a repeated start, the second reads from 0xFF, which
        // no seven-bit filter value can match.
        set_filters(7'd127, DIR_WR);
        send_item(KIND_START, rand_sample(), rand_sample(), rand_payload(), '0);
        send_item(KIND_ADDR_WRITE, rand_sample(), rand_sample(), 64'h0123_4567_89AB_CD7F, 4'd1);
        send_item(KIND_DATA_WRITE, rand_sample(), rand_sample(), rand_payload(), 4'd4);
        send_item(KIND_START_REPEAT, rand_sample(), rand_sample(), rand_payload(), '0);
        send_item(KIND_ADDR_READ, rand_sample(), rand_sample(), 64'hFEDC_BA98_7654_32FF, 4'd2);
        send_item(KIND_STOP, rand_sample(), rand_sample(), rand_payload(), '0);
        wait_idle();

        // The unused direction code rejects even an otherwise open filter.
        set_filters('0, DIR_REJECT_ALL);
        send_item(KIND_START, rand_sample(), rand_sample(), rand_payload(), '0);
        send_item(KIND_ADDR_READ, rand_sample(), rand_sample(), rand_payload(), 4'd1);
        send_item(KIND_STOP, rand_sample(), rand_sample(), rand_payload(), '0);

        // Random phases, each under its own filter setting.
        base = items_sent;
        phase = 0;
        while (items_sent - base < RANDOM_ITEMS) begin
            wait_idle();
            case (phase % 4)
                0:       target = '0;
                1:       target = 7'd127;
                default: target = MATCH_W'($urandom_range(1, 126));
            endcase
            dir = ($urandom_range(0, 7) == 0) ? DIR_REJECT_ALL : DIR_W'($urandom_range(0, 2));
            eager_sender = ($urandom_range(0, 3) == 0);
            if (phase == 2) begin
                // Overfill the buffer while the result side holds off: the
                // surplus events are dropped, the drain stalls and the input
                // channel has to back up behind it.
                eager_sender = 1'b1;
                set_filters('0, DIR_ANY);
                want_hold = 1'b1;
                send_transaction('0, 70);
                send_transaction('0, 3);
            end else begin
                set_filters(target, dir);
                repeat ($urandom_range(2, 4)) begin
                    if ($urandom_range(0, 9) == 0) begin
                        repeat ($urandom_range(1, 4))
                            send_item(KIND_W'($urandom), rand_sample(), rand_sample(),
                                      rand_payload(), COUNT_W'($urandom));
                    end
                    send_transaction(target, ($urandom_range(0, 9) == 0) ?
                                             $urandom_range(20, 40) : $urandom_range(0, 8));
                end
            end
            phase++;
        end

        // Wait for the last bursts to drain, with a bound of our own.
        s_valid <= 1'b0;
        @(posedge aclk);
        waited = 0;
        while (pending_count != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("PASS");
        end else begin
            if (pending_count != 0) $display("%0d forwarded items never arrived", pending_count);
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
